### sv/z80_io_instruction_unit_assert.svh
// Assertion macros shared by the I/O instruction unit RTL.
`ifndef Z80_IO_INSTRUCTION_UNIT_ASSERT_SVH
`define Z80_IO_INSTRUCTION_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define Z80IO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("z80io check failed");

// Next-cycle implication, checked outside reset
`define Z80IO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("z80io check failed");

`endif

### sv/z80io_pkg.sv
// Types and constants of the Z80 I/O instruction unit.
package z80io_pkg;

    // Instruction codes
    localparam logic [2:0] CMD_IN_A_N  = 3'd0;
    localparam logic [2:0] CMD_IN_R_C  = 3'd1;
    localparam logic [2:0] CMD_INI     = 3'd2;
    localparam logic [2:0] CMD_IND     = 3'd3;
    localparam logic [2:0] CMD_OUT_N_A = 3'd4;
    localparam logic [2:0] CMD_OUT_C_R = 3'd5;
    localparam logic [2:0] CMD_OUTI    = 3'd6;
    localparam logic [2:0] CMD_OUTD    = 3'd7;

    // T-state counts
    localparam logic [4:0] T_SHORT  = 5'd11;
    localparam logic [4:0] T_IO     = 5'd12;
    localparam logic [4:0] T_BLOCK  = 5'd16;
    localparam logic [4:0] T_REPEAT = 5'd21;

    typedef struct packed {
        logic [2:0]  command;
        logic        repeat_req;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [7:0]  reg_c;
        logic [15:0] reg_hl;
        logic [7:0]  flags_in;
        logic [7:0]  imm_port;
        logic [7:0]  port_in;
        logic [7:0]  mem_in;
        logic [7:0]  out_value;
    } req_t;

    typedef struct packed {
        logic [15:0] port_addr;
        logic [7:0]  data_out;
        logic [15:0] mem_addr;
        logic [7:0]  new_b;
        logic [15:0] new_hl;
        logic [15:0] memptr;
        logic [7:0]  flags_out;
        logic        flags_written;
        logic [4:0]  tstates;
        logic        repeat_again;
    } rsp_t;

endpackage

### sv/z80_io_instruction_unit.sv
// Z80 I/O instruction unit: one IN/OUT/block I/O instruction per item.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | req_t (instruction and operands)
//  rsp     | out       | rsp_valid/rsp_ready | rsp_t (addresses, data, flags)
//
// One item per cycle sustained while rsp_ready stays high; each item passes through two registers
// (input register, then result register after the decode logic).
// The result register frees up whenever rsp_ready is high, so a stalled
// output holds at most two items before req_ready drops.
// rst_n clears both valid flags asynchronously; payload is not reset.
`include "z80_io_instruction_unit_assert.svh"

module z80_io_instruction_unit
    import z80io_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic s1_valid_reg;
    logic s1_valid_next;
    req_t s1_item_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_item_reg;
    rsp_t rsp_item_next;
    logic s1_advance;

    // Block instruction terms
    logic [15:0] bc_old;
    logic [7:0]  nb;
    logic [15:0] bc_new;
    logic        blk_inc;
    logic        blk_in;
    logic [7:0]  blk_byte;
    logic [15:0] blk_hl;
    logic [15:0] blk_port;
    logic [15:0] blk_wz;
    logic [7:0]  blk_addend;
    logic [8:0]  blk_k;
    logic        blk_again;
    logic [7:0]  blk_flags;
    logic [7:0]  in_flags;

    // Handshake: stage 1 moves on when the result register is free
    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_advance;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_item_reg;

    always_comb
    begin
        s1_valid_next = req_ready ? req_valid : s1_valid_reg;
        if (s1_advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Block forms: B decrement, HL step, port, WZ and flags
    assign bc_old     = {s1_item_reg.reg_b, s1_item_reg.reg_c};
    assign nb         = s1_item_reg.reg_b - 8'd1;
    assign bc_new     = {nb, s1_item_reg.reg_c};
    assign blk_inc    = (s1_item_reg.command == CMD_INI) || (s1_item_reg.command == CMD_OUTI);
    assign blk_in     = (s1_item_reg.command == CMD_INI) || (s1_item_reg.command == CMD_IND);
    assign blk_byte   = blk_in ? s1_item_reg.port_in : s1_item_reg.mem_in;
    assign blk_hl     = blk_inc ? (s1_item_reg.reg_hl + 16'd1) : (s1_item_reg.reg_hl - 16'd1);
    assign blk_port   = blk_in ? bc_old : bc_new;
    assign blk_wz     = blk_inc ? (blk_port + 16'd1) : (blk_port - 16'd1);
    assign blk_addend = blk_in ? (blk_inc ? (s1_item_reg.reg_c + 8'd1)
                                          : (s1_item_reg.reg_c - 8'd1))
                               : blk_hl[7:0];
    assign blk_k      = {1'b0, blk_byte} + {1'b0, blk_addend};
    assign blk_again  = s1_item_reg.repeat_req && (nb != 8'd0);
    assign blk_flags  = {nb[7], (nb == 8'd0), nb[5], blk_k[8], nb[3],
                         ~^{nb[7:3], blk_k[2:0] ^ nb[2:0]}, blk_byte[7], blk_k[8]};

    // IN r,(C) flags: SZ53P from the byte, carry kept
    assign in_flags = {s1_item_reg.port_in[7], (s1_item_reg.port_in == 8'd0),
                       s1_item_reg.port_in[5], 1'b0, s1_item_reg.port_in[3],
                       ~^s1_item_reg.port_in, 1'b0, s1_item_reg.flags_in[0]};

    // Result decode
    always_comb
    begin
        rsp_item_next               = '0;
        rsp_item_next.new_b         = s1_item_reg.reg_b;
        rsp_item_next.new_hl        = s1_item_reg.reg_hl;
        rsp_item_next.flags_out     = s1_item_reg.flags_in;
        rsp_item_next.tstates       = T_IO;
        case (s1_item_reg.command)
            CMD_IN_A_N:
            begin
                rsp_item_next.port_addr = {s1_item_reg.reg_a, s1_item_reg.imm_port};
                rsp_item_next.data_out  = s1_item_reg.port_in;
                rsp_item_next.memptr    = {s1_item_reg.reg_a, s1_item_reg.imm_port} + 16'd1;
                rsp_item_next.tstates   = T_SHORT;
            end
            CMD_IN_R_C:
            begin
                rsp_item_next.port_addr     = bc_old;
                rsp_item_next.data_out      = s1_item_reg.port_in;
                rsp_item_next.memptr        = bc_old + 16'd1;
                rsp_item_next.flags_out     = in_flags;
                rsp_item_next.flags_written = 1'b1;
            end
            CMD_OUT_N_A:
            begin
                rsp_item_next.port_addr = {s1_item_reg.reg_a, s1_item_reg.imm_port};
                rsp_item_next.data_out  = s1_item_reg.reg_a;
                rsp_item_next.memptr    = {s1_item_reg.reg_a, s1_item_reg.imm_port + 8'd1};
                rsp_item_next.tstates   = T_SHORT;
            end
            CMD_OUT_C_R:
            begin
                rsp_item_next.port_addr = bc_old;
                rsp_item_next.data_out  = s1_item_reg.out_value;
                rsp_item_next.memptr    = bc_old + 16'd1;
            end
            CMD_INI, CMD_IND, CMD_OUTI, CMD_OUTD:
            begin
                rsp_item_next.port_addr     = blk_port;
                rsp_item_next.data_out      = blk_byte;
                rsp_item_next.mem_addr      = s1_item_reg.reg_hl;
                rsp_item_next.new_b         = nb;
                rsp_item_next.new_hl        = blk_hl;
                rsp_item_next.memptr        = blk_wz;
                rsp_item_next.flags_out     = blk_flags;
                rsp_item_next.flags_written = 1'b1;
                rsp_item_next.tstates       = blk_again ? T_REPEAT : T_BLOCK;
                rsp_item_next.repeat_again  = blk_again;
            end
            default:
            begin
                rsp_item_next.tstates = T_IO;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_item_reg <= req;
        end
        if (s1_advance)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    // Checks
    `Z80IO_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, req_valid && req_ready, s1_valid_reg)
    `Z80IO_ASSERT_NEXT(a_advance_fills_rsp, clk, rst_n, s1_advance, rsp_valid_reg)
    `Z80IO_ASSERT_NOW(a_repeat_tstates, clk, rst_n, rsp_valid && rsp.repeat_again, rsp.tstates == T_REPEAT)
    `Z80IO_ASSERT_NOW(a_repeat_b_nonzero, clk, rst_n, rsp_valid && rsp.repeat_again, rsp.new_b != 8'd0)
    `Z80IO_ASSERT_NOW(a_noflag_no_mem, clk, rst_n, rsp_valid && !rsp.flags_written, rsp.mem_addr == 16'd0)

endmodule

### tb/z80_io_instruction_unit_check.sv
// Result checker for the Z80 I/O instruction unit: predicts each item and compares results.
`timescale 1ns / 100ps

module z80_io_instruction_unit_check
    import z80io_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    // F register bit positions
    localparam logic [7:0] F_SIGN  = 8'h80;
    localparam logic [7:0] F_ZERO  = 8'h40;
    localparam logic [7:0] F_B5    = 8'h20;
    localparam logic [7:0] F_HALF  = 8'h10;
    localparam logic [7:0] F_B3    = 8'h08;
    localparam logic [7:0] F_PAR   = 8'h04;
    localparam logic [7:0] F_SUB   = 8'h02;
    localparam logic [7:0] F_CARRY = 8'h01;

    rsp_t predicted_io[$];
    rsp_t want;

    // S, Z and the two undocumented bits of a byte
    function automatic logic [7:0] sign_zero_xy(input logic [7:0] v);
        return (v & (F_SIGN | F_B5 | F_B3)) | ((v == 8'h00) ? F_ZERO : 8'h00);
    endfunction

    // Outcome of one I/O instruction
    function automatic rsp_t execute_io(input req_t r);
        rsp_t        o;
        logic [15:0] bc_old;
        logic [15:0] bc_new;
        logic [7:0]  nb;
        logic [7:0]  xfer;
        logic [7:0]  k_add;
        logic [8:0]  k;
        logic        step_up;
        o = '0;
        o.new_b = r.reg_b;
        o.new_hl = r.reg_hl;
        o.flags_out = r.flags_in;
        o.tstates = T_IO;
        bc_old = {r.reg_b, r.reg_c};
        case (r.command)
            CMD_IN_A_N:
            begin
                o.port_addr = {r.reg_a, r.imm_port};
                o.data_out = r.port_in;
                o.memptr = {r.reg_a, r.imm_port} + 16'd1;
                o.tstates = T_SHORT;
            end
            CMD_IN_R_C:
            begin
                o.port_addr = bc_old;
                o.data_out = r.port_in;
                o.memptr = bc_old + 16'd1;
                o.flags_out = sign_zero_xy(r.port_in) | ((~^r.port_in) ? F_PAR : 8'h00)
                            | (r.flags_in & F_CARRY);
                o.flags_written = 1'b1;
            end
            CMD_OUT_N_A:
            begin
                o.port_addr = {r.reg_a, r.imm_port};
                o.data_out = r.reg_a;
                o.memptr = {r.reg_a, r.imm_port + 8'd1};
                o.tstates = T_SHORT;
            end
            CMD_OUT_C_R:
            begin
                o.port_addr = bc_old;
                o.data_out = r.out_value;
                o.memptr = bc_old + 16'd1;
            end
            default:
            begin
                // block forms: INI, IND, OUTI, OUTD
                step_up = (r.command == CMD_INI) || (r.command == CMD_OUTI);
                nb = r.reg_b - 8'd1;
                o.new_b = nb;
                o.mem_addr = r.reg_hl;
                o.new_hl = step_up ? r.reg_hl + 16'd1 : r.reg_hl - 16'd1;
                if (r.command == CMD_INI || r.command == CMD_IND)
                begin
                    // port read goes to memory; address uses B before decrement
                    xfer = r.port_in;
                    o.port_addr = bc_old;
                    o.memptr = step_up ? bc_old + 16'd1 : bc_old - 16'd1;
                    k_add = step_up ? r.reg_c + 8'd1 : r.reg_c - 8'd1;
                end
                else
                begin
                    // memory byte goes to port; address uses B after decrement
                    bc_new = {nb, r.reg_c};
                    xfer = r.mem_in;
                    o.port_addr = bc_new;
                    o.memptr = step_up ? bc_new + 16'd1 : bc_new - 16'd1;
                    k_add = o.new_hl[7:0];
                end
                o.data_out = xfer;
                k = {1'b0, xfer} + {1'b0, k_add};
                o.flags_out = sign_zero_xy(nb)
                            | ((~^({5'd0, k[2:0]} ^ nb)) ? F_PAR : 8'h00)
                            | (k[8] ? (F_HALF | F_CARRY) : 8'h00)
                            | (xfer[7] ? F_SUB : 8'h00);
                o.flags_written = 1'b1;
                o.tstates = T_BLOCK;
                if (r.repeat_req && nb != 8'h00)
                begin
                    o.repeat_again = 1'b1;
                    o.tstates = T_REPEAT;
                end
            end
        endcase
        return o;
    endfunction

    task automatic check_field(input string field, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: %s expected %h, got %h", $time, field, exp_v, got_v);
        end
    endtask

    // Track accepted items and compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            predicted_io.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                predicted_io.push_back(execute_io(req));
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_io.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t ns: result with no item outstanding: %h", $time, rsp);
                end
                else
                begin
                    want = predicted_io.pop_front();
                    check_field("port_addr", want.port_addr, rsp.port_addr);
                    check_field("data_out", 16'(want.data_out), 16'(rsp.data_out));
                    check_field("mem_addr", want.mem_addr, rsp.mem_addr);
                    check_field("new_b", 16'(want.new_b), 16'(rsp.new_b));
                    check_field("new_hl", want.new_hl, rsp.new_hl);
                    check_field("memptr", want.memptr, rsp.memptr);
                    check_field("flags_out", 16'(want.flags_out), 16'(rsp.flags_out));
                    check_field("flags_written", 16'(want.flags_written),
                                16'(rsp.flags_written));
                    check_field("tstates", 16'(want.tstates), 16'(rsp.tstates));
                    check_field("repeat_again", 16'(want.repeat_again),
                                16'(rsp.repeat_again));
                end
            end
            outstanding = predicted_io.size();
        end
    end

endmodule

### tb/z80_io_instruction_unit_test.sv
// Top of the Z80 I/O instruction unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module z80_io_instruction_unit_test
    import z80io_pkg::*;
();

    localparam int RANDOM_ITEMS = 650;
    localparam int STEADY_FROM  = 300;
    localparam int STEADY_TO    = 420;
    localparam int HOLD_AT      = 320;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;
    int   sent_count = 0;
    logic steady;

    // window with no idling on either side, used for the long output hold
    assign steady = (sent_count >= STEADY_FROM) && (sent_count < STEADY_TO);

    z80_io_instruction_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    z80_io_instruction_unit_check checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random instruction; B, C and HL lean toward their wrap points now and then
    function automatic req_t random_item();
        req_t it;
        it.command    = 3'($urandom_range(0, 7));
        it.repeat_req = 1'($urandom_range(0, 1));
        it.reg_a      = 8'($urandom_range(0, 255));
        it.reg_b      = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 2))
                                                    : 8'($urandom_range(0, 255));
        it.reg_c      = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
        it.reg_hl     = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                    : 16'($urandom_range(0, 65535));
        it.flags_in   = 8'($urandom_range(0, 255));
        it.imm_port   = 8'($urandom_range(0, 255));
        it.port_in    = 8'($urandom_range(0, 255));
        it.mem_in     = 8'($urandom_range(0, 255));
        it.out_value  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Offer one item after an optional gap and hold it until accepted
    task automatic send_item(input req_t item);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sent_count++;
    endtask

    // Extremes of each instruction and the wrap and repeat corner cases
    task automatic run_directed();
        req_t it;
        // IN A,(n): all zero, then all ones with a stray repeat request
        it = '0; it.command = CMD_IN_A_N; send_item(it);
        it = '1; it.command = CMD_IN_A_N; send_item(it);
        // IN r,(C): zero byte keeps carry, BC+1 wraps
        it = '1; it.command = CMD_IN_R_C; it.port_in = 8'h00; it.repeat_req = 1'b0;
        send_item(it);
        it = '0; it.command = CMD_IN_R_C; it.port_in = 8'h80; send_item(it);
        it = '1; it.command = CMD_IN_R_C; send_item(it);
        // OUT (n),A: low byte of WZ wraps without carry into A
        it = '1; it.command = CMD_OUT_N_A; send_item(it);
        it = '0; it.command = CMD_OUT_N_A; send_item(it);
        // OUT (C),r: zero byte form and all ones with repeat request
        it = '0; it.command = CMD_OUT_C_R; send_item(it);
        it = '1; it.command = CMD_OUT_C_R; send_item(it);
        // INI: B reaches zero, C+1 wraps, HL wraps up, repeat stops
        it = random_item(); it.command = CMD_INI; it.repeat_req = 1'b1;
        it.reg_b = 8'h01; it.reg_c = 8'hFF; it.port_in = 8'hFF; it.reg_hl = 16'hFFFF;
        send_item(it);
        // INIR: B wraps below zero, carry out of k, repeats
        it = random_item(); it.command = CMD_INI; it.repeat_req = 1'b1;
        it.reg_b = 8'h00; it.reg_c = 8'h80; it.port_in = 8'h80; send_item(it);
        it = random_item(); it.command = CMD_INI; it.repeat_req = 1'b1;
        it.reg_b = 8'h02; send_item(it);
        // IND: C-1 wraps, HL wraps down
        it = random_item(); it.command = CMD_IND; it.repeat_req = 1'b0;
        it.reg_b = 8'h01; it.reg_c = 8'h00; it.port_in = 8'h01; it.reg_hl = 16'h0000;
        send_item(it);
        it = random_item(); it.command = CMD_IND; it.repeat_req = 1'b1;
        it.reg_b = 8'h80; it.reg_c = 8'h10; it.port_in = 8'h7F; send_item(it);
        // OUTI: new L wraps to zero, then HL wraps up, then carry from new L
        it = random_item(); it.command = CMD_OUTI; it.repeat_req = 1'b1;
        it.reg_b = 8'h01; it.mem_in = 8'hFF; it.reg_hl = 16'h00FF; send_item(it);
        it = random_item(); it.command = CMD_OUTI; it.repeat_req = 1'b0;
        it.reg_hl = 16'hFFFF; it.mem_in = 8'h01; send_item(it);
        it = random_item(); it.command = CMD_OUTI; it.repeat_req = 1'b1;
        it.reg_b = 8'h05; it.mem_in = 8'h80; it.reg_hl = 16'h1280; send_item(it);
        // OTDR: B wraps, HL wraps down, carry, repeats
        it = random_item(); it.command = CMD_OUTD; it.repeat_req = 1'b1;
        it.reg_b = 8'h00; it.reg_hl = 16'h0000; it.mem_in = 8'hFF; send_item(it);
        it = random_item(); it.command = CMD_OUTD; it.repeat_req = 1'b1;
        it.reg_b = 8'h01; it.mem_in = 8'h00; send_item(it);
        it = '0; it.command = CMD_OUTD; send_item(it);
    endtask

    // Sender side: reset, directed items, random items, drain and verdict
    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        repeat (RANDOM_ITEMS) send_item(random_item());
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver side: random stalls plus one long hold while items keep coming
    initial
    begin : result_side
        int stall_left;
        bit held_off;
        stall_left = 0;
        held_off = 1'b0;
        rsp_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && sent_count >= HOLD_AT)
            begin
                held_off = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (!steady)
                    stall_left = pick_gap();
            end
        end
    end

    // Cycle limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
